// ===== sv/aob_pkg.sv =====
// aob_pkg: shared types and constants for the alpha overlay blender
// beat payload structs, configuration struct and inter-stage structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package aob_pkg;

  // overlay store geometry
  localparam int OVL_MAX_W  = 128;
  localparam int OVL_MAX_H  = 128;
  localparam int COORD_BITS = 12;
  localparam int STORE_DEPTH = OVL_MAX_W * OVL_MAX_H;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // fixed field widths
  localparam int CHAN_W = 8;
  localparam int POS_W  = 13;
  localparam int SIZE_W = 8;
  // frame coordinate minus signed offset, one bit of headroom
  localparam int DIFF_W = POS_W + 1;
  // bg*(255-a)+fg*a stays below 2^16
  localparam int SUM_W  = 2 * CHAN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVL_HEIGHT = 2'd3;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [CHAN_W-1:0]     chan0;
    logic [CHAN_W-1:0]     chan1;
    logic [CHAN_W-1:0]     chan2;
    logic [CHAN_W-1:0]     alpha;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic              inside_res;
  } out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       ovl_width;
    logic [SIZE_W-1:0]       ovl_height;
  } cfg_t;

  // locate stage to store stage
  typedef struct packed {
    logic              is_write;
    logic              wr_ok;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic [CHAN_W-1:0] alpha;
  } loc_t;

  // store stage to mix stage
  typedef struct packed {
    logic              hit;
    logic [CHAN_W-1:0] bg0;
    logic [CHAN_W-1:0] bg1;
    logic [CHAN_W-1:0] bg2;
    logic [CHAN_W-1:0] fg0;
    logic [CHAN_W-1:0] fg1;
    logic [CHAN_W-1:0] fg2;
    logic [CHAN_W-1:0] alpha;
  } pix_t;

  // mix stage to divide stage
  typedef struct packed {
    logic             hit;
    logic [SUM_W-1:0] s0;
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s2;
  } sum_t;

endpackage

`default_nettype wire

// ===== sv/aob_locate.sv =====
// aob_locate: input register stage and overlay hit test
// computes the store address for writes and blends; uses aob_pkg
`timescale 1ns / 1ps
`default_nettype none

module aob_locate (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire aob_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire aob_pkg::in_t  in_data,
  output logic               loc_valid,
  input  wire logic          loc_ready,
  output aob_pkg::loc_t      loc
);
  import aob_pkg::*;

  in_t  a_r;
  logic a_v_r;
  logic a_load;

  logic [SIZE_W-1:0]       w_sat;
  logic [SIZE_W-1:0]       h_sat;
  logic signed [DIFF_W-1:0] fx;
  logic signed [DIFF_W-1:0] fy;
  logic                    hit;

  // stage a takes a beat when empty or draining
  assign in_ready = !a_v_r || loc_ready;
  assign a_load   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_r <= in_data;
    end
  end

  // overlay size clamped to the store
  assign w_sat = (cfg.ovl_width > SIZE_W'(OVL_MAX_W)) ? SIZE_W'(OVL_MAX_W) : cfg.ovl_width;
  assign h_sat = (cfg.ovl_height > SIZE_W'(OVL_MAX_H)) ? SIZE_W'(OVL_MAX_H) : cfg.ovl_height;

  // position relative to the overlay's top left corner
  assign fx = signed'(DIFF_W'(a_r.col)) - DIFF_W'(cfg.pos_x);
  assign fy = signed'(DIFF_W'(a_r.row)) - DIFF_W'(cfg.pos_y);

  assign hit = !fx[DIFF_W-1] && !fy[DIFF_W-1] &&
               (fx < signed'(DIFF_W'(w_sat))) && (fy < signed'(DIFF_W'(h_sat)));

  // address and payload toward the store
  always_comb begin
    loc.is_write = (a_r.command == CMD_WRITE);
    loc.wr_ok    = (32'(a_r.col) < OVL_MAX_W) && (32'(a_r.row) < OVL_MAX_H);
    loc.hit      = hit;
    if (a_r.command == CMD_WRITE) begin
      loc.addr = ADDR_W'(32'(a_r.row) * OVL_MAX_W + 32'(a_r.col));
    end else begin
      loc.addr = ADDR_W'(32'(fy[COORD_BITS-1:0]) * OVL_MAX_W + 32'(fx[COORD_BITS-1:0]));
    end
    loc.c0    = a_r.chan0;
    loc.c1    = a_r.chan1;
    loc.c2    = a_r.chan2;
    loc.alpha = a_r.alpha;
  end

  assign loc_valid = a_v_r;

endmodule

`default_nettype wire

// ===== sv/aob_store.sv =====
// aob_store: overlay pixel memory and read stage
// single port, write beats store, blend beats read; uses aob_pkg
`timescale 1ns / 1ps
`default_nettype none

module aob_store (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          loc_valid,
  output logic               loc_ready,
  input  wire aob_pkg::loc_t loc,
  output logic               pix_valid,
  input  wire logic          pix_ready,
  output aob_pkg::pix_t      pix
);
  import aob_pkg::*;

  logic [4*CHAN_W-1:0] mem [STORE_DEPTH];
  logic [4*CHAN_W-1:0] rd_r;
  logic                b_v_r;
  logic                inside_r;
  logic [CHAN_W-1:0]   bg0_r;
  logic [CHAN_W-1:0]   bg1_r;
  logic [CHAN_W-1:0]   bg2_r;
  logic                b_adv;
  logic                take;

  assign loc_ready = !b_v_r || pix_ready;
  assign b_adv     = loc_ready;
  assign take      = b_adv && loc_valid;

  // memory port: write for write beats, registered read for blends
  always_ff @(posedge clk) begin
    if (take) begin
      if (loc.is_write) begin
        if (loc.wr_ok) begin
          mem[loc.addr] <= {loc.alpha, loc.c2, loc.c1, loc.c0};
        end
      end else begin
        rd_r <= mem[loc.addr];
      end
    end
  end

  // write beats end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_adv) begin
      b_v_r <= loc_valid && !loc.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      inside_r <= loc.hit;
      bg0_r    <= loc.c0;
      bg1_r    <= loc.c1;
      bg2_r    <= loc.c2;
    end
  end

  // unpack stored overlay pixel
  always_comb begin
    pix.hit    = inside_r;
    pix.bg0    = bg0_r;
    pix.bg1    = bg1_r;
    pix.bg2    = bg2_r;
    pix.fg0    = rd_r[CHAN_W-1:0];
    pix.fg1    = rd_r[2*CHAN_W-1:CHAN_W];
    pix.fg2    = rd_r[3*CHAN_W-1:2*CHAN_W];
    pix.alpha  = rd_r[4*CHAN_W-1:3*CHAN_W];
  end

  assign pix_valid = b_v_r;

endmodule

`default_nettype wire

// ===== sv/aob_mix.sv =====
// aob_mix: weighted sum stage, bg*(255-a) + fg*a per channel
// outside pixels use a zero weight so the sum is bg*255; uses aob_pkg
`timescale 1ns / 1ps
`default_nettype none

module aob_mix (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pix_valid,
  output logic               pix_ready,
  input  wire aob_pkg::pix_t pix,
  output logic               sum_valid,
  input  wire logic          sum_ready,
  output aob_pkg::sum_t      sum
);
  import aob_pkg::*;

  sum_t              c_r;
  logic              c_v_r;
  logic [CHAN_W-1:0] a_eff;
  logic [CHAN_W-1:0] a_inv;
  logic [CHAN_W-1:0] f0;
  logic [CHAN_W-1:0] f1;
  logic [CHAN_W-1:0] f2;
  sum_t              c_nxt;

  assign pix_ready = !c_v_r || sum_ready;

  // weights, foreground masked for pass-through
  assign a_eff = pix.hit ? pix.alpha : '0;
  assign a_inv = CHAN_MAX - a_eff;
  assign f0    = pix.hit ? pix.fg0 : '0;
  assign f1    = pix.hit ? pix.fg1 : '0;
  assign f2    = pix.hit ? pix.fg2 : '0;

  always_comb begin
    c_nxt.hit = pix.hit;
    c_nxt.s0 = SUM_W'(pix.bg0) * SUM_W'(a_inv) + SUM_W'(f0) * SUM_W'(a_eff);
    c_nxt.s1 = SUM_W'(pix.bg1) * SUM_W'(a_inv) + SUM_W'(f1) * SUM_W'(a_eff);
    c_nxt.s2 = SUM_W'(pix.bg2) * SUM_W'(a_inv) + SUM_W'(f2) * SUM_W'(a_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (pix_ready) begin
      c_v_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      c_r <= c_nxt;
    end
  end

  assign sum_valid = c_v_r;
  assign sum       = c_r;

endmodule

`default_nettype wire

// ===== sv/aob_div.sv =====
// aob_div: divide-by-255 stage and output register
// floor(s/255) = (s + 1 + (s >> 8)) >> 8 for any s up to 255*255; uses aob_pkg
`timescale 1ns / 1ps
`default_nettype none

module aob_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          sum_valid,
  output logic               sum_ready,
  input  wire aob_pkg::sum_t sum,
  output logic               out_valid,
  input  wire logic          out_ready,
  output aob_pkg::out_t      out_data
);
  import aob_pkg::*;

  out_t d_r;
  logic d_v_r;
  out_t d_nxt;

  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(s >> CHAN_W) + (SUM_W+1)'(1);
    return t[SUM_W-1:CHAN_W];
  endfunction

  assign sum_ready = !d_v_r || out_ready;

  always_comb begin
    d_nxt.out_chan0  = div255(sum.s0);
    d_nxt.out_chan1  = div255(sum.s1);
    d_nxt.out_chan2  = div255(sum.s2);
    d_nxt.inside_res = sum.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (sum_ready) begin
      d_v_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_data  = d_r;

endmodule

`default_nettype wire

// ===== sv/alpha_overlay_blend_top.sv =====
// alpha_overlay_blend_top: RGBA overlay composited onto a 3-channel pixel stream
// instantiates aob_locate, aob_store, aob_mix, aob_div; uses aob_pkg
//
// Usage:
//   in_*  : valid/ready beats. command 0 writes one overlay pixel (colors and
//           alpha) at overlay col/row; writes outside the 128x128 store are
//           dropped. command 1 blends one frame pixel at frame col/row.
//   out_* : one result beat per blend beat, in order; write beats give none.
//   cfg_* : write enable, index and data; pos_x, pos_y, ovl_width, ovl_height.
//           Write only while no beat is in flight.
// Timing: four register stages (input, store read, weighted sum, divide and
//   output), a blend result registered in each in turn; one beat is taken
//   every cycle when the receiver keeps up, the single-port overlay memory
//   serving one write or one read per cycle.
// Reset clears the pipeline valid bits and the position and size registers
//   (no overlay); store contents stay undefined until written.
// When out_ready is low each stage holds its beat and bubbles still fill in,
//   so in_ready drops only when all four stages are full.
`timescale 1ns / 1ps
`default_nettype none

module alpha_overlay_blend_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire aob_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output aob_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [aob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [aob_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import aob_pkg::*;

  cfg_t cfg_r;
  logic loc_valid;
  logic loc_ready;
  loc_t loc;
  logic pix_valid;
  logic pix_ready;
  pix_t pix;
  logic sum_valid;
  logic sum_ready;
  sum_t sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_X:      cfg_r.pos_x      <= signed'(cfg_wdata[POS_W-1:0]);
        CFG_POS_Y:      cfg_r.pos_y      <= signed'(cfg_wdata[POS_W-1:0]);
        CFG_OVL_WIDTH:  cfg_r.ovl_width  <= cfg_wdata[SIZE_W-1:0];
        CFG_OVL_HEIGHT: cfg_r.ovl_height <= cfg_wdata[SIZE_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  aob_locate u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc       (loc)
  );

  aob_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc       (loc),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  aob_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  aob_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
